FILE: rtl/rsld_pkg.sv
// rsld_pkg: types, constants and register indexes of the layout table decoder
// no dependencies; used by the interfaces, the decode stage and the core
package rsld_pkg;

  localparam int IMAGE_DWORDS_DEF = 1024;
  localparam int POS_W            = 11;
  localparam int IDX_W            = 10;
  localparam int WORD_W           = 32;
  localparam int CNT_W            = 6;
  localparam int ACC_W            = 30;
  localparam int BYTE_W           = 8;
  localparam int CFG_IDX_W        = 2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_OPCODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSTED_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_BASE = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] load_opcode_word;
    logic [WORD_W-1:0] posted_mask;
    logic [WORD_W-1:0] engine_base;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             in_offsets;
    logic [CNT_W-1:0] remaining;
    logic [ACC_W-1:0] accumulator;
  } dec_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  write_index;
    logic [WORD_W-1:0] write_value;
    logic              is_header;
    logic              table_done;
    logic              out_of_range;
  } result_t;

endpackage

FILE: rtl/rsld_if.sv
// rsld_in_if / rsld_out_if: valid-ready channels for table bytes and write results
// depends on rsld_pkg for field widths
interface rsld_in_if import rsld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] layout_byte;

  modport source (output valid, output layout_byte, input ready);
  modport sink   (input valid, input layout_byte, output ready);
endinterface

interface rsld_out_if import rsld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  write_index;
  logic [WORD_W-1:0] write_value;
  logic              is_header;
  logic              table_done;
  logic              out_of_range;

  modport source (output valid, output write_index, output write_value, output is_header,
                  output table_done, output out_of_range, input ready);
  modport sink   (input valid, input write_index, input write_value, input is_header,
                  input table_done, input out_of_range, output ready);
endinterface

FILE: rtl/rsld_decode.sv
// rsld_decode: one-byte decode of the layout table, next state and optional result
// depends on rsld_pkg
module rsld_decode import rsld_pkg::*; #(
  parameter int IMAGE_DWORDS = IMAGE_DWORDS_DEF
) (
  input  cfg_t              cfg,
  input  dec_state_t        st,
  input  logic [BYTE_W-1:0] layout_byte,
  output dec_state_t        st_next,
  output logic              emit,
  output result_t           res
);

  logic [ACC_W-1:0]  acc_shift;
  logic [6:0]        adv;
  logic [POS_W:0]    pos_sum;
  logic [POS_W-1:0]  pos_sat;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rem_dec;
  logic [WORD_W-1:0] header_word;
  logic              oor;

  assign acc_shift = {st.accumulator[ACC_W-8:0], layout_byte[6:0]};
  assign count     = layout_byte[CNT_W-1:0];
  assign rem_dec   = st.remaining - CNT_W'(1);
  assign oor       = 32'(st.position) >= 32'(IMAGE_DWORDS);

  // skip length, or 2 per finished offset, or 1 per header
  always_comb begin
    if (st.in_offsets) begin
      adv = 7'd2;
    end else if (layout_byte[7]) begin
      adv = layout_byte[6:0];
    end else begin
      adv = 7'd1;
    end
  end

  assign pos_sum = {1'b0, st.position} + (POS_W+1)'(adv);
  assign pos_sat = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

  // (2*count - 1) mod 2^32 ORed into the opcode word, plus the posted mask when bit 6 is set
  always_comb begin
    header_word = cfg.load_opcode_word | ({(WORD_W-CNT_W-1)'(0), count, 1'b0} - WORD_W'(1));
    if (layout_byte[6]) begin
      header_word = header_word | cfg.posted_mask;
    end
  end

  always_comb begin
    st_next          = st;
    emit             = 1'b0;
    res.write_index  = st.position[IDX_W-1:0];
    res.write_value  = header_word;
    res.is_header    = 1'b0;
    res.table_done   = 1'b0;
    res.out_of_range = oor;
    if (st.in_offsets) begin
      st_next.accumulator = acc_shift;
      if (!layout_byte[7]) begin
        emit                = 1'b1;
        res.write_value     = cfg.engine_base + {acc_shift, 2'b00};
        st_next.position    = pos_sat;
        st_next.accumulator = '0;
        st_next.remaining   = rem_dec;
        st_next.in_offsets  = (rem_dec != '0);
      end
    end else if (layout_byte[7]) begin
      st_next.position = pos_sat;
    end else if (layout_byte == '0) begin
      emit             = 1'b1;
      res              = '0;
      res.table_done   = 1'b1;
      st_next          = '0;
    end else begin
      emit                = 1'b1;
      res.is_header       = 1'b1;
      st_next.position    = pos_sat;
      st_next.accumulator = '0;
      st_next.remaining   = count;
      st_next.in_offsets  = (count != '0);
    end
  end

endmodule

FILE: rtl/register_state_layout_decoder_core.sv
// register_state_layout_decoder_core: top level of the layout table decoder
// depends on rsld_pkg, rsld_if (rsld_in_if, rsld_out_if) and rsld_decode
//
//   channel   dir  form             payload
//   layout    in   valid/ready      layout_byte[7:0]
//   result    out  valid/ready      write_index, write_value, is_header,
//                                   table_done, out_of_range
//   cfg_*     in   write enable     cfg_index[1:0], cfg_data[31:0]
//
// one table byte per cycle while no result stall holds it; a result appears in the output
// register the cycle after its byte is taken
// this is set by the single decode stage: state update and result compute are both
// combinational from the decode state register
// rst is synchronous, active high; it clears the decode state, config registers and
// the output valid bit
// the layout side stays ready while the output register is empty or being taken, so a
// stall on the result side holds the pending result and back-pressures the input
module register_state_layout_decoder_core import rsld_pkg::*; #(
  parameter int IMAGE_DWORDS = IMAGE_DWORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  rsld_in_if.sink              layout,
  rsld_out_if.source           result
);

  cfg_t       cfg;
  dec_state_t st;
  dec_state_t st_next;
  logic       emit;
  result_t    res;
  result_t    res_q;
  logic       out_valid;
  logic       take;

  // configuration registers; write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOAD_OPCODE: cfg.load_opcode_word <= cfg_data;
        REG_POSTED_MASK: cfg.posted_mask      <= cfg_data;
        REG_ENGINE_BASE: cfg.engine_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte decode: skip, terminator, header or offset group
  rsld_decode #(
    .IMAGE_DWORDS(IMAGE_DWORDS)
  ) u_decode (
    .cfg        (cfg),
    .st         (st),
    .layout_byte(layout.layout_byte),
    .st_next    (st_next),
    .emit       (emit),
    .res        (res)
  );

  // input is taken whenever the output register is free or draining this cycle
  assign layout.ready = !out_valid || result.ready;
  assign take         = layout.valid && layout.ready;

  // decode state advances on every transfer in
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // output register valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_q <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.write_index  = res_q.write_index;
  assign result.write_value  = res_q.write_value;
  assign result.is_header    = res_q.is_header;
  assign result.table_done   = res_q.table_done;
  assign result.out_of_range = res_q.out_of_range;

endmodule

FILE: rtl/rsld_checker.sv
// rsld_checker: port-level assertions for the layout table decoder core
// depends on rsld_pkg; bound to register_state_layout_decoder_core below
module rsld_checker import rsld_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  write_index,
  input logic [WORD_W-1:0] write_value,
  input logic              is_header,
  input logic              table_done,
  input logic              out_of_range
);

  // stalled result holds its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // stalled result holds its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(write_value) && $stable(write_index))
    else $error("result payload changed while stalled");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  // terminator marker carries no write
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_done |-> write_index == '0 && write_value == '0 && !is_header
      && !out_of_range)
    else $error("terminator result carries write fields");

  // a new result needs a transfer in on the previous cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result appeared without an input transfer");

endmodule

bind register_state_layout_decoder_core rsld_checker u_rsld_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (layout.valid),
  .in_ready    (layout.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .write_index (result.write_index),
  .write_value (result.write_value),
  .is_header   (result.is_header),
  .table_done  (result.table_done),
  .out_of_range(result.out_of_range)
);

FILE: sim/tb_register_state_layout_decoder_core.sv
// testbench for register_state_layout_decoder_core: layout table bytes in, image writes out
// depends on rsld_pkg and rsld_if; checks every write against an in-bench model of the decoder
`timescale 1ns / 100ps

module tb_register_state_layout_decoder_core;
  import rsld_pkg::*;

  localparam int IMAGE_DWORDS = IMAGE_DWORDS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  // idle wait after the last expected write, before config or the end
  localparam int DRAIN_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOAD_OPCODE;
  logic [WORD_W-1:0]    cfg_data = '0;

  rsld_in_if  layout_ch ();
  rsld_out_if result_ch ();

  register_state_layout_decoder_core #(
    .IMAGE_DWORDS(IMAGE_DWORDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .layout   (layout_ch),
    .result   (result_ch)
  );

  always #6 clk = ~clk;

  // decoder model: shadow of the config registers and of the decode state
  cfg_t       model_cfg;
  dec_state_t model_state;

  // writes predicted for accepted bytes, oldest first
  result_t expected_writes[$];

  int mismatches     = 0;
  int bytes_sent     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  // position moves forward and sticks at its 11-bit maximum
  function automatic void advance_position(input logic [7:0] n);
    logic [POS_W:0] sum;
    sum = {1'b0, model_state.position} + {{(POS_W-7){1'b0}}, n};
    model_state.position = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
  endfunction

  function automatic void decode_layout_byte(input logic [7:0] b, output bit produced,
                                             output result_t r);
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] word;
    produced = 1'b0;
    r        = '0;
    if (model_state.in_offsets) begin
      // big-endian 7-bit groups, only the low 30 bits survive
      model_state.accumulator = {model_state.accumulator[ACC_W-8:0], b[6:0]};
      if (!b[7]) begin
        produced       = 1'b1;
        r.write_index  = model_state.position[IDX_W-1:0];
        r.write_value  = model_cfg.engine_base + {model_state.accumulator, 2'b00};
        r.out_of_range = (32'(model_state.position) >= 32'(IMAGE_DWORDS));
        advance_position(8'd2);
        model_state.accumulator = '0;
        model_state.remaining   = model_state.remaining - CNT_W'(1);
        if (model_state.remaining == '0)
          model_state.in_offsets = 1'b0;
      end
    end else if (b[7]) begin
      // skip, no write
      advance_position({1'b0, b[6:0]});
    end else if (b == 8'h00) begin
      // terminator: done marker, state back to reset
      produced     = 1'b1;
      r.table_done = 1'b1;
      model_state  = '0;
    end else begin
      // load header, count of zero still writes the word with all bits set
      count = b[5:0];
      word  = model_cfg.load_opcode_word | ({25'd0, count, 1'b0} - 32'd1);
      if (b[6])
        word = word | model_cfg.posted_mask;
      produced       = 1'b1;
      r.write_index  = model_state.position[IDX_W-1:0];
      r.write_value  = word;
      r.is_header    = 1'b1;
      r.out_of_range = (32'(model_state.position) >= 32'(IMAGE_DWORDS));
      advance_position(8'd1);
      model_state.accumulator = '0;
      model_state.remaining   = count;
      model_state.in_offsets  = (count != '0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // offer one byte, starting and ending at a falling edge; valid stays high on return
  task automatic send_byte(input logic [7:0] b);
    bit      produced;
    result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      layout_ch.valid <= 1'b0;
      @(negedge clk);
    end
    layout_ch.valid       <= 1'b1;
    layout_ch.layout_byte <= b;
    @(posedge clk);
    while (!layout_ch.ready)
      @(posedge clk);
    // transfer happened at this edge
    decode_layout_byte(b, produced, want);
    if (produced)
      expected_writes.push_back(want);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sender goes quiet until every predicted write has come out
  task automatic drain_results();
    layout_ch.valid <= 1'b0;
    while (expected_writes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // all three registers, only while the decoder is idle
  task automatic write_config(input logic [WORD_W-1:0] opcode, mask, base);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOAD_OPCODE;
    cfg_data  <= opcode;
    @(negedge clk);
    cfg_index <= REG_POSTED_MASK;
    cfg_data  <= mask;
    @(negedge clk);
    cfg_index <= REG_ENGINE_BASE;
    cfg_data  <= base;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_cfg.load_opcode_word = opcode;
    model_cfg.posted_mask      = mask;
    model_cfg.engine_base      = base;
    @(negedge clk);
  endtask

  // result side ready: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_writes
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.write_index  = result_ch.write_index;
      got.write_value  = result_ch.write_value;
      got.is_header    = result_ch.is_header;
      got.table_done   = result_ch.table_done;
      got.out_of_range = result_ch.out_of_range;
      if (expected_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write, actual idx=%0d val=%h hdr=%b done=%b oor=%b",
                 $time, got.write_index, got.write_value, got.is_header,
                 got.table_done, got.out_of_range);
      end else begin
        want = expected_writes.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: write mismatch, expected idx=%0d val=%h hdr=%b done=%b oor=%b",
                   $time, want.write_index, want.write_value, want.is_header,
                   want.table_done, want.out_of_range);
          $display("%0t:                 actual   idx=%0d val=%h hdr=%b done=%b oor=%b",
                   $time, got.write_index, got.write_value, got.is_header,
                   got.table_done, got.out_of_range);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one well-formed table with random content, now and then a stray or cut-short entry
  task automatic send_table();
    int         entries;
    int         kind;
    int         count;
    int         groups;
    int         pick;
    logic [7:0] b;
    entries = $urandom_range(1, 8);
    repeat (entries) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // skip
        b = 8'($urandom_range(0, 127));
        b[7] = 1'b1;
        send_byte(b);
      end else if (kind < 22) begin
        // noise byte, anything goes
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // load header and its offsets; counts mostly small, a few up to the maximum
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
        b = {1'b0, 1'($urandom_range(0, 1)), 6'(count)};
        if (b == 8'h00)
          b = 8'h40;
        send_byte(b);
        for (int i = 0; i < count; i++) begin
          // cut the list short once in a while, the next bytes then land in offset mode
          if ($urandom_range(0, 39) == 0)
            break;
          pick   = $urandom_range(0, 9);
          groups = (pick < 5) ? 1 : (pick < 8) ? 2 : (pick < 9) ? 3 : $urandom_range(4, 6);
          repeat (groups - 1) begin
            b = 8'($urandom_range(0, 127));
            b[7] = 1'b1;
            send_byte(b);
          end
          send_byte(8'($urandom_range(0, 127)));
        end
      end
    end
    // terminator (a zero group instead if a stray byte left us mid-offset)
    send_byte(8'h00);
  endtask

  // extremes of the byte and each special case of the decode
  task automatic test_directed();
    write_config(32'h1100_0000, 32'h0020_0000, 32'hffff_fff0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(8'h00);                 // terminator straight out of reset
    send_byte(8'h40);                 // header, count zero, posted
    send_byte(8'h01);                 // header, count one
    send_byte(8'h00);                 // zero byte in offset mode is a final group
    send_byte(8'h42);                 // header, count two, posted
    repeat (4) send_byte(8'hff);      // long offset, overflows the 30-bit accumulator
    send_byte(8'h7f);                 // base wraps past 2^32
    send_byte(8'h05);                 // short offset
    send_byte(8'h80);                 // skip of zero
    repeat (17) send_byte(8'hff);     // skips of 127 until position saturates
    send_byte(8'h41);                 // header beyond the image
    send_byte(8'h7f);                 // offset beyond the image
    send_byte(8'h00);                 // terminator clears position
    drain_results();
  endtask

  task automatic test_random_tables(input int n_items, input int send_pct, input int recv_pct);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start          = bytes_sent;
    while (bytes_sent - start < n_items)
      send_table();
    drain_results();
  endtask

  // receiver holds off for a long stretch while bytes keep coming, then the sender waits it out
  task automatic test_backpressure();
    int start;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 300;
    start          = bytes_sent;
    while (bytes_sent - start < 40)
      send_table();
    drain_results();
  endtask

  initial begin
    layout_ch.valid       = 1'b0;
    layout_ch.layout_byte = '0;
    result_ch.ready       = 1'b0;
    model_cfg             = '0;
    model_state           = '0;

    // synchronous reset
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();

    // low extremes of every register, no idling
    write_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    test_random_tables(150, 0, 0);

    // random settings, sender mostly idle
    write_config($urandom, $urandom, $urandom);
    test_random_tables(150, 71, 0);

    // high extremes, receiver mostly stalling
    write_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    test_random_tables(150, 0, 71);

    // random settings, both sides idling
    write_config($urandom, $urandom, $urandom);
    test_random_tables(150, 34, 34);

    write_config($urandom, $urandom, $urandom);
    test_backpressure();

    recv_stall_pct = 0;
    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rsld_pkg.sv
rtl/rsld_if.sv
rtl/rsld_decode.sv
rtl/register_state_layout_decoder_core.sv
rtl/rsld_checker.sv
sim/tb_register_state_layout_decoder_core.sv
